>>> rtl/ctt_pkg.sv
// ============================================================================
// ctt_pkg: shared types and constants of the command text tokenizer
// Character codes, scan modes, token kinds and the token record that travels
// from the lexer to the token queue.
// ============================================================================
package ctt_pkg;

  // Position counter width; lengths carry one more bit
  localparam int POS_WIDTH = 16;
  localparam int LEN_WIDTH = POS_WIDTH + 1;
  localparam int UNIT_WIDTH = 16;
  localparam int KIND_WIDTH = 3;
  localparam int MODE_WIDTH = 3;

  // Token queue depth (power of two)
  localparam int TQ_DEPTH = 4;
  localparam int TQ_AW = $clog2(TQ_DEPTH);

  // Scan modes
  localparam logic [MODE_WIDTH-1:0] MODE_IDLE     = 3'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_SIGN     = 3'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_NUMBER   = 3'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_QUOTED   = 3'd3;
  localparam logic [MODE_WIDTH-1:0] MODE_UNQUOTED = 3'd4;

  // Token kinds
  localparam logic [KIND_WIDTH-1:0] KIND_LF     = 3'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_SPACE  = 3'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_NUMBER = 3'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_SYMBOL = 3'd3;
  localparam logic [KIND_WIDTH-1:0] KIND_STRING = 3'd4;

  // Character codes
  localparam logic [UNIT_WIDTH-1:0] CH_LF     = 16'h000A;
  localparam logic [UNIT_WIDTH-1:0] CH_SPACE  = 16'h0020;
  localparam logic [UNIT_WIDTH-1:0] CH_QUOTE  = 16'h0022;
  localparam logic [UNIT_WIDTH-1:0] CH_PLUS   = 16'h002B;
  localparam logic [UNIT_WIDTH-1:0] CH_MINUS  = 16'h002D;
  localparam logic [UNIT_WIDTH-1:0] CH_DOT    = 16'h002E;
  localparam logic [UNIT_WIDTH-1:0] CH_ZERO   = 16'h0030;
  localparam logic [UNIT_WIDTH-1:0] CH_NINE   = 16'h0039;
  localparam logic [UNIT_WIDTH-1:0] CH_COLON  = 16'h003A;
  localparam logic [UNIT_WIDTH-1:0] CH_BSLASH = 16'h005C;

  typedef struct packed {
    logic [KIND_WIDTH-1:0] kind;
    logic [POS_WIDTH-1:0]  start;
    logic [LEN_WIDTH-1:0]  len;
    logic                  last;
    logic                  ovf;
  } token_t;

  // Up to two tokens produced by one code unit
  typedef struct packed {
    logic [1:0] cnt;
    token_t     t0;
    token_t     t1;
  } tok_pair_t;

  // Punctuation that stands alone outside strings
  function automatic logic is_common_punct(input logic [UNIT_WIDTH-1:0] c);
    logic hit;
    hit = 1'b0;
    case (c) inside
      16'h002C, 16'h0040, 16'h007E, 16'h005E, 16'h002F, 16'h0024, 16'h0026,
      16'h0027, 16'h0021, 16'h0023, 16'h0025, 16'h002A, 16'h003D, 16'h005B,
      16'h007B, 16'h005D, 16'h007D, 16'h005C, 16'h007C, 16'h003C, 16'h003E,
      16'h0060: hit = 1'b1;
      default:  hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

>>> rtl/command_text_tokenizer.sv
// ============================================================================
// command_text_tokenizer: streaming lexer for command text
// Turns UTF-16 code units into newline, space, number, symbol and string
// tokens, each given as kind, start position and length.
// ============================================================================
//
//  channel | direction | beat contents
//  --------+-----------+----------------------------------------------------
//  in_     | input     | code_unit, end_of_content
//  out_    | output    | token_kind, start_pos, token_len, last_in_run,
//          |           | pos_overflow
//
// One code unit is taken every cycle while the token queue has room. A beat
// is held in the input register, lexed once the queue has room and then
// written to the token queue, whose head offers its first token. A unit that
// closes one token and emits another needs two output beats; the four-entry
// token queue absorbs these. The input stalls while a beat waits in the input
// register and the queue has fewer than two free entries.
// Reset (rst_n low, synchronous) empties both registers and the queue and
// starts a new content at position 0.
module command_text_tokenizer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ctt_pkg::UNIT_WIDTH-1:0]   in_code_unit,
  input  logic                             in_end_of_content,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ctt_pkg::KIND_WIDTH-1:0]   out_token_kind,
  output logic [ctt_pkg::POS_WIDTH-1:0]    out_start_pos,
  output logic [ctt_pkg::LEN_WIDTH-1:0]    out_token_len,
  output logic                             out_last_in_run,
  output logic                             out_pos_overflow
);
  import ctt_pkg::*;

  logic                  in_vld_r;
  logic [UNIT_WIDTH-1:0] code_r;
  logic                  eoc_r;
  logic                  room;
  logic                  step_en;
  logic                  in_take;
  tok_pair_t             tok_pair;
  token_t                rd_tok;

  assign step_en  = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (step_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      code_r <= in_code_unit;
      eoc_r  <= in_end_of_content;
    end
  end

  ctt_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .code    (code_r),
    .eoc     (eoc_r),
    .tok_o   (tok_pair)
  );

  ctt_tok_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_i       (tok_pair),
    .room_o     (room),
    .rd_vld_o   (out_valid),
    .rd_stall_i (out_stall),
    .rd_tok_o   (rd_tok)
  );

  // Unpack the head token
  assign out_token_kind   = rd_tok.kind;
  assign out_start_pos    = rd_tok.start;
  assign out_token_len    = rd_tok.len;
  assign out_last_in_run  = rd_tok.last;
  assign out_pos_overflow = rd_tok.ovf;

  // A held input beat is lexed as soon as the queue has room
  a_step_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && room) |=> (!in_vld_r || $past(in_take)))
    else $error("input beat held despite queue room");

  // Tokens are written only while a beat is lexed
  a_tok_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_pair.cnt != 2'd0) |-> step_en)
    else $error("tokens written without a lexed beat");

  // Delivered tokens are never empty
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_token_len != '0))
    else $error("token of zero length delivered");

endmodule

>>> rtl/ctt_lexer.sv
// ============================================================================
// ctt_lexer: scan state and per-unit token decision
// Classifies one registered code unit, updates the scan state and produces
// up to two tokens for the token queue.
// ============================================================================
module ctt_lexer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_en,
  input  logic [ctt_pkg::UNIT_WIDTH-1:0]   code,
  input  logic                             eoc,
  output ctt_pkg::tok_pair_t               tok_o
);
  import ctt_pkg::*;

  logic [MODE_WIDTH-1:0] mode_r, mode_nxt;
  logic                  esc_r, esc_nxt;
  logic [POS_WIDTH-1:0]  open_r, open_nxt;
  logic [LEN_WIDTH-1:0]  pos_r;
  logic                  ovf_r, ovf_nxt;

  // Character classes
  logic is_lf, is_sp, is_dd, is_sign, is_sym, is_quote, is_bs, is_num, is_delim;

  assign is_lf    = (code == CH_LF);
  assign is_sp    = (code == CH_SPACE);
  assign is_dd    = ((code >= CH_ZERO) && (code <= CH_NINE)) || (code == CH_DOT);
  assign is_sign  = (code == CH_PLUS) || (code == CH_MINUS);
  assign is_sym   = is_common_punct(code) || (code == CH_COLON);
  assign is_quote = (code == CH_QUOTE);
  assign is_bs    = (code == CH_BSLASH);
  assign is_num   = is_dd || is_sign;
  assign is_delim = is_common_punct(code) || (code == CH_PLUS) || is_quote || is_sp || is_lf;

  // Saturated position of this unit and the counter after it
  logic                 sat;
  logic [POS_WIDTH-1:0] p;
  logic [LEN_WIDTH-1:0] incl, len_excl, len_incl;

  assign sat      = pos_r[POS_WIDTH];
  assign p        = sat ? {POS_WIDTH{1'b1}} : pos_r[POS_WIDTH-1:0];
  assign incl     = sat ? pos_r : pos_r + LEN_WIDTH'(1);
  assign len_excl = pos_r - {1'b0, open_r};
  assign len_incl = incl - {1'b0, open_r};
  assign ovf_nxt  = ovf_r | sat;

  // Fresh-start decision for the current unit
  logic                  f_emit;
  logic [KIND_WIDTH-1:0] f_kind;
  logic [MODE_WIDTH-1:0] f_mode;

  always_comb begin
    f_emit = 1'b0;
    f_kind = KIND_SYMBOL;
    f_mode = MODE_IDLE;
    if (is_lf) begin
      f_emit = 1'b1;
      f_kind = KIND_LF;
    end else if (is_sp) begin
      f_emit = 1'b1;
      f_kind = KIND_SPACE;
    end else if (is_dd) begin
      f_mode = MODE_NUMBER;
    end else if (is_sign) begin
      f_mode = MODE_SIGN;
    end else if (is_sym) begin
      f_emit = 1'b1;
    end else if (is_quote) begin
      f_mode = MODE_QUOTED;
    end else begin
      f_mode = MODE_UNQUOTED;
    end
  end

  // Close the open token and decide the next mode
  token_t a_tok, b_tok, c_tok;
  logic   a_vld, b_vld, c_vld, fresh;

  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    open_nxt = open_r;
    a_vld    = 1'b0;
    fresh    = 1'b0;
    a_tok    = '0;
    a_tok.start = open_r;
    a_tok.kind  = KIND_SYMBOL;
    a_tok.len   = LEN_WIDTH'(1);
    unique case (mode_r)
      MODE_SIGN: begin
        if (is_dd) begin
          mode_nxt = MODE_NUMBER;
        end else begin
          a_vld = 1'b1;
          fresh = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (!is_num) begin
          a_vld      = 1'b1;
          a_tok.kind = KIND_NUMBER;
          a_tok.len  = len_excl;
          fresh      = 1'b1;
        end
      end
      MODE_QUOTED: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (is_bs) begin
          esc_nxt = 1'b1;
        end else if (is_quote) begin
          a_vld      = 1'b1;
          a_tok.kind = KIND_STRING;
          a_tok.len  = len_incl;
          mode_nxt   = MODE_IDLE;
        end
      end
      MODE_UNQUOTED: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (is_bs) begin
          esc_nxt = 1'b1;
        end else if (is_delim) begin
          a_vld      = 1'b1;
          a_tok.kind = KIND_STRING;
          a_tok.len  = len_excl;
          fresh      = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase
    if (fresh) begin
      esc_nxt  = 1'b0;
      mode_nxt = f_mode;
      open_nxt = p;
    end
  end

  // One-unit token of a fresh start
  always_comb begin
    b_vld       = fresh && f_emit;
    b_tok       = '0;
    b_tok.kind  = f_kind;
    b_tok.start = p;
    b_tok.len   = LEN_WIDTH'(1);
  end

  // Flush the open token at end of content
  always_comb begin
    c_vld       = 1'b0;
    c_tok       = '0;
    c_tok.start = open_nxt;
    c_tok.kind  = KIND_STRING;
    c_tok.len   = incl - {1'b0, open_nxt};
    if (eoc) begin
      unique case (mode_nxt) inside
        MODE_SIGN: begin
          c_vld      = 1'b1;
          c_tok.kind = KIND_SYMBOL;
          c_tok.len  = LEN_WIDTH'(1);
        end
        MODE_NUMBER: begin
          c_vld      = 1'b1;
          c_tok.kind = KIND_NUMBER;
        end
        MODE_QUOTED, MODE_UNQUOTED: begin
          c_vld = 1'b1;
        end
        default: c_vld = 1'b0;
      endcase
    end
  end

  // Pack tokens in order; mark the last one of this unit
  always_comb begin
    tok_o = '0;
    if (a_vld) begin
      tok_o.t0 = a_tok;
      if (b_vld) begin
        tok_o.t1  = b_tok;
        tok_o.cnt = 2'd2;
      end else if (c_vld) begin
        tok_o.t1  = c_tok;
        tok_o.cnt = 2'd2;
      end else begin
        tok_o.cnt = 2'd1;
      end
    end else if (b_vld) begin
      tok_o.t0  = b_tok;
      tok_o.cnt = 2'd1;
    end else if (c_vld) begin
      tok_o.t0  = c_tok;
      tok_o.cnt = 2'd1;
    end
    tok_o.t0.last = (tok_o.cnt == 2'd1);
    tok_o.t1.last = 1'b1;
    tok_o.t0.ovf  = ovf_nxt;
    tok_o.t1.ovf  = ovf_nxt;
    if (!step_en) begin
      tok_o.cnt = 2'd0;
    end
  end

  // Advance scan state; end of content starts a new content
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      esc_r  <= 1'b0;
      open_r <= '0;
      pos_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (step_en) begin
      if (eoc) begin
        mode_r <= MODE_IDLE;
        esc_r  <= 1'b0;
        open_r <= '0;
        pos_r  <= '0;
        ovf_r  <= 1'b0;
      end else begin
        mode_r <= mode_nxt;
        esc_r  <= esc_nxt;
        open_r <= open_nxt;
        pos_r  <= incl;
        ovf_r  <= ovf_nxt;
      end
    end
  end

  // End of content returns the scan state to its start
  a_eoc_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && eoc) |=> (mode_r == MODE_IDLE && pos_r == '0 && !ovf_r && !esc_r))
    else $error("scan state not cleared after end of content");

  // Escape is only pending inside a string
  a_esc_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (mode_r == MODE_QUOTED || mode_r == MODE_UNQUOTED))
    else $error("escape pending outside a string");

  // Overflow flag only once the counter has saturated
  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (pos_r == {1'b1, {POS_WIDTH{1'b0}}}))
    else $error("overflow flag without a saturated counter");

  // A fresh one-unit token and a flush never come from the same unit
  a_tok_pair: assert property (@(posedge clk) disable iff (!rst_n)
    !(b_vld && c_vld))
    else $error("fresh one-unit token and flush in the same unit");

endmodule

>>> rtl/ctt_tok_queue.sv
// ============================================================================
// ctt_tok_queue: result queue for tokens
// Takes zero, one or two tokens per cycle and delivers one token per beat.
// ============================================================================
module ctt_tok_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  ctt_pkg::tok_pair_t  wr_i,
  output logic                room_o,
  output logic                rd_vld_o,
  input  logic                rd_stall_i,
  output ctt_pkg::token_t     rd_tok_o
);
  import ctt_pkg::*;

  token_t           mem_r [TQ_DEPTH];
  logic [TQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [TQ_AW:0]   count_r, count_nxt;
  logic             pop;

  assign room_o   = (count_r <= (TQ_AW+1)'(TQ_DEPTH - 2));
  assign rd_vld_o = (count_r != '0);
  assign rd_tok_o = mem_r[rd_ptr_r];
  assign pop      = rd_vld_o && !rd_stall_i;

  assign count_nxt = count_r + (TQ_AW+1)'(wr_i.cnt) - (TQ_AW+1)'(pop);

  // Store incoming tokens
  always_ff @(posedge clk) begin
    if (wr_i.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= wr_i.t0;
    end
    if (wr_i.cnt == 2'd2) begin
      mem_r[wr_ptr_r + TQ_AW'(1)] <= wr_i.t1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + TQ_AW'(wr_i.cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + TQ_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Writes never exceed the free space
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_i.cnt != 2'd0) |-> (count_r + wr_i.cnt <= TQ_DEPTH))
    else $error("token queue overflow");

  // Fill count stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= TQ_DEPTH)
    else $error("token queue count out of range");

  // Pointer distance matches the fill count
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[TQ_AW-1:0])
    else $error("token queue pointers disagree with count");

endmodule
